/* design/tkhf_pkg.sv */
`default_nettype none
package tkhf_pkg;

    localparam int HW  = 64;
    localparam int CW  = 32;
    localparam int LKW = 7;
    localparam int MRW = 4;
    localparam int NUMW = CW + LKW;
    localparam int TABLE_DEPTH_DEF = 128;
    localparam int MAX_OUT_DEF = 8;
    localparam int PCT_FULL = 100;
    localparam logic [MRW-1:0] MAX_RESULTS_RST = 4'd8;

    typedef enum logic [1:0] {
        REG_MAX_RESULTS   = 2'd0,
        REG_CALLER_FILTER = 2'd1,
        REG_VALUE_MODE    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [HW-1:0] handle;
        logic          is_unknown;
        logic [HW-1:0] caller;
        logic          last;
    } in_item_t;

    typedef struct packed {
        logic [HW-1:0]  entry_handle;
        logic [LKW-1:0] likelihood;
        logic           valid_res;
        logic           final_res;
    } out_item_t;

    typedef struct packed {
        logic          found;
        logic [CW-1:0] cnt;
        logic [HW-1:0] hdl;
    } tok_t;

    typedef struct packed {
        logic          obs_en;
        logic          ins_en;
        logic [HW-1:0] hdl;
        logic          unk;
        logic          clear;
        logic          taken_clr;
        logic          take_en;
        logic          vmode;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OBS,
        ST_SCAN,
        ST_PICK,
        ST_DIV,
        ST_TOP,
        ST_RD,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

/* design/tkhf_cell.sv */
`default_nettype none
module tkhf_cell (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  tkhf_pkg::cell_ctrl_t    ctrl,
    input  wire                     prev_occ,
    input  tkhf_pkg::tok_t          tok_in,
    output tkhf_pkg::tok_t          tok_out,
    output logic                    occ,
    output logic                    match,
    output logic                    unk,
    output logic [tkhf_pkg::CW-1:0] cnt
);
    import tkhf_pkg::*;

    logic [HW-1:0] hdl_reg;
    logic [CW-1:0] cnt_reg;
    logic          unk_reg;
    logic          occ_reg;
    logic          taken_reg;
    tok_t          tok_reg;
    tok_t          tok_next;
    logic          hit;
    logic          elig;

    assign hit  = occ_reg && (hdl_reg == ctrl.hdl);
    assign elig = occ_reg && !taken_reg && !(!ctrl.vmode && unk_reg);

    always_comb begin
        tok_next = tok_in;
        if (elig && (!tok_in.found || cnt_reg > tok_in.cnt)) begin
            tok_next.found = 1'b1;
            tok_next.cnt   = cnt_reg;
            tok_next.hdl   = hdl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= 1'b0;
            taken_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            tok_reg <= tok_next;
            if (ctrl.clear) begin
                occ_reg <= 1'b0;
            end else if (ctrl.ins_en && prev_occ && !occ_reg) begin
                occ_reg <= 1'b1;
            end
            if (ctrl.taken_clr) begin
                taken_reg <= 1'b0;
            end else if (ctrl.take_en && hit) begin
                taken_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ins_en && prev_occ && !occ_reg) begin
            hdl_reg <= ctrl.hdl;
            cnt_reg <= CW'(1);
            unk_reg <= ctrl.unk;
        end else if (ctrl.obs_en && hit && cnt_reg != '1) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    assign tok_out = tok_reg;
    assign occ     = occ_reg;
    assign match   = hit;
    assign unk     = unk_reg;
    assign cnt     = cnt_reg;

endmodule
`default_nettype wire

/* design/tkhf_div.sv */
`default_nettype none
module tkhf_div (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start,
    input  wire  [tkhf_pkg::NUMW-1:0] num,
    input  wire  [tkhf_pkg::CW-1:0]   den,
    output logic                      done,
    output logic [tkhf_pkg::LKW-1:0]  quo
);
    import tkhf_pkg::*;

    localparam int BW = $clog2(LKW);

    logic [NUMW-1:0] rem_reg;
    logic [LKW-1:0]  q_reg;
    logic [BW-1:0]   bit_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [NUMW-1:0] dsh;
    logic            ge;

    assign dsh = NUMW'(den) << bit_reg;
    assign ge  = rem_reg >= dsh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            q_reg   <= '0;
            bit_reg <= BW'(LKW - 1);
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh;
            end
            q_reg[bit_reg] <= ge;
            if (bit_reg != '0) begin
                bit_reg <= bit_reg - BW'(1);
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(busy_reg))
        else $error("divider done without run");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !busy_reg)
        else $error("divider busy after done");

endmodule
`default_nettype wire

/* design/top_k_handle_frequency.sv */
// Channel   Ports                         Moves
// input     s_valid s_ready s_data        one observation per transfer
// result    m_valid m_ready m_data        one ranked entry per transfer
// config    cfg_we cfg_index cfg_wdata    register write, no wait
//
// An item that is not last is latched, then matched in parallel over the cells.
// A last item: a match step, then per ranked entry a token sweep, a pick and a divide,
// for up to min(max_results, MAX_OUT) entries, one closing sweep, a wrap-up step, then
// a read and an output step per result (or one empty final result) plus any output stall.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// s_ready drops for the cycle after a transfer, and after a last item until the final result.
`default_nettype none
module top_k_handle_frequency #(
    parameter int TABLE_DEPTH = tkhf_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_OUT     = tkhf_pkg::MAX_OUT_DEF
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  tkhf_pkg::in_item_t        s_data,
    output logic                      m_valid,
    input  wire                       m_ready,
    output tkhf_pkg::out_item_t       m_data,
    input  wire                       cfg_we,
    input  wire  [1:0]                cfg_index,
    input  wire  [tkhf_pkg::HW-1:0]   cfg_wdata
);
    import tkhf_pkg::*;

    localparam int SCW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW  = $clog2(MAX_OUT + 1);
    localparam int AW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int SW  = 16;

    logic [MRW-1:0] max_results_reg;
    logic [HW-1:0]  caller_filter_reg;
    logic           value_mode_reg;

    state_t         state_reg, state_next;
    in_item_t       item_reg;
    logic [CW-1:0]  total_reg;
    logic           any_unk_reg;
    logic [SCW-1:0] scnt_reg;
    logic [NW-1:0]  n_reg;
    logic [SW-1:0]  sum_reg;
    logic [LKW-1:0] lk0_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic           m_valid_reg;
    out_item_t      m_data_reg;

    logic [HW+LKW-1:0] res_mem [MAX_OUT];
    logic [HW-1:0]     best_hdl_reg;

    cell_ctrl_t             ctrl;
    tok_t                   tok [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0]   occ_ext;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] unk_vec;
    logic [CW-1:0]          cnt_vec [TABLE_DEPTH];

    logic           keep;
    logic           any_match;
    logic           full;
    logic           used_two;
    logic           force_empty;
    logic           no_topup;
    logic [31:0]    lim32;
    logic           n_done;
    logic           take;
    logic           scan_end;
    logic           div_done;
    logic [LKW-1:0] div_q;
    logic           last_out;

    assign tok[0] = '0;
    assign occ_ext[TABLE_DEPTH] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            tkhf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .prev_occ ((gi == 0) ? 1'b1 : occ_ext[(gi == 0) ? 0 : gi - 1]),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1]),
                .occ      (occ_ext[gi]),
                .match    (match_vec[gi]),
                .unk      (unk_vec[gi]),
                .cnt      (cnt_vec[gi])
            );
        end
    endgenerate

    assign keep = (item_reg.handle != '0) &&
                  ((caller_filter_reg == '0) || (item_reg.caller == caller_filter_reg));
    assign any_match = |match_vec;
    assign full      = occ_ext[TABLE_DEPTH-1];
    assign used_two  = occ_ext[1] && !occ_ext[2];
    assign force_empty = !value_mode_reg && used_two && !unk_vec[0] && unk_vec[1] &&
                         (cnt_vec[0] < cnt_vec[1]);
    assign no_topup  = !value_mode_reg && (any_unk_reg || used_two);
    assign lim32     = (32'(max_results_reg) < 32'(MAX_OUT)) ? 32'(max_results_reg)
                                                              : 32'(MAX_OUT);
    assign n_done    = 32'(n_reg) >= lim32;
    assign take      = (state_reg == ST_PICK) && tok[TABLE_DEPTH].found && !n_done;
    assign scan_end  = scnt_reg == SCW'(TABLE_DEPTH - 1);
    assign last_out  = 32'(rd_ptr_reg) + 32'd1 == 32'(n_reg);

    tkhf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (take),
        .num     (NUMW'(tok[TABLE_DEPTH].cnt) * NUMW'(PCT_FULL)),
        .den     (total_reg),
        .done    (div_done),
        .quo     (div_q)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_OBS;
            end
            ST_OBS:  state_next = item_reg.last ? ST_SCAN : ST_IDLE;
            ST_SCAN: begin
                if (scan_end) state_next = ST_PICK;
            end
            ST_PICK: state_next = take ? ST_DIV : ST_TOP;
            ST_DIV: begin
                if (div_done) state_next = ST_SCAN;
            end
            ST_TOP:  state_next = (n_reg == '0 || force_empty) ? ST_OUT : ST_RD;
            ST_RD:   state_next = ST_OUT;
            ST_OUT: begin
                if (m_valid_reg && m_ready) begin
                    state_next = m_data_reg.final_res ? ST_IDLE : ST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.obs_en    = (state_reg == ST_OBS) && keep;
        ctrl.ins_en    = (state_reg == ST_OBS) && keep && !any_match;
        ctrl.hdl       = (state_reg == ST_PICK) ? tok[TABLE_DEPTH].hdl : item_reg.handle;
        ctrl.unk       = item_reg.is_unknown;
        ctrl.clear     = (state_reg == ST_TOP);
        ctrl.taken_clr = (state_reg == ST_OBS) && item_reg.last;
        ctrl.take_en   = take;
        ctrl.vmode     = value_mode_reg;
        s_ready        = (state_reg == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_results_reg   <= MAX_RESULTS_RST;
            caller_filter_reg <= '0;
            value_mode_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAX_RESULTS:   max_results_reg   <= cfg_wdata[MRW-1:0];
                REG_CALLER_FILTER: caller_filter_reg <= cfg_wdata;
                REG_VALUE_MODE:    value_mode_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            any_unk_reg <= 1'b0;
            scnt_reg    <= '0;
            n_reg       <= '0;
            sum_reg     <= '0;
            rd_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_OBS: begin
                    if (keep && total_reg != '1) total_reg <= total_reg + CW'(1);
                    if (keep && !any_match && !full && item_reg.is_unknown) begin
                        any_unk_reg <= 1'b1;
                    end
                    scnt_reg <= '0;
                    n_reg    <= '0;
                    sum_reg  <= '0;
                end
                ST_SCAN: scnt_reg <= scnt_reg + SCW'(1);
                ST_DIV: begin
                    scnt_reg <= '0;
                    if (div_done) begin
                        n_reg   <= n_reg + NW'(1);
                        sum_reg <= sum_reg + SW'(div_q);
                    end
                end
                ST_TOP: begin
                    total_reg   <= '0;
                    any_unk_reg <= 1'b0;
                    rd_ptr_reg  <= '0;
                    if (n_reg == '0 || force_empty) m_valid_reg <= 1'b1;
                end
                ST_RD: m_valid_reg <= 1'b1;
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        rd_ptr_reg  <= rd_ptr_reg + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) item_reg <= s_data;
        if (take) best_hdl_reg <= tok[TABLE_DEPTH].hdl;
        if (state_reg == ST_DIV && div_done) begin
            res_mem[n_reg[AW-1:0]] <= {best_hdl_reg, div_q};
            if (n_reg == '0) lk0_reg <= div_q;
        end
        if (state_reg == ST_TOP) begin
            if (n_reg != '0 && !no_topup && sum_reg < SW'(PCT_FULL)) begin
                lk0_reg <= LKW'(SW'(lk0_reg) + SW'(PCT_FULL) - sum_reg);
            end
        end
        if (state_reg == ST_TOP && (n_reg == '0 || force_empty)) begin
            m_data_reg <= '{entry_handle: '0, likelihood: '0, valid_res: 1'b0,
                            final_res: 1'b1};
        end else if (state_reg == ST_RD) begin
            m_data_reg.entry_handle <= res_mem[rd_ptr_reg][HW+LKW-1:LKW];
            m_data_reg.likelihood   <= (rd_ptr_reg == '0) ? lk0_reg
                                                          : res_mem[rd_ptr_reg][LKW-1:0];
            m_data_reg.valid_res    <= 1'b1;
            m_data_reg.final_res    <= last_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_one_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("handle present in more than one cell");

    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == ST_OUT)
        else $error("result shown outside output state");

    a_n_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(n_reg) <= 32'(MAX_OUT))
        else $error("result count overflow");

    a_empty_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.valid_res) |-> m_data_reg.final_res)
        else $error("empty result not final");

    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_DIV) |-> !s_ready)
        else $error("input taken during ranking");

endmodule
`default_nettype wire
